@@ hw/rtl/text_console_cell_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Text console cell engine assertion macros
// Shared concurrent assertion forms for the console RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TCCE_ASSERT_SAME(name, clk_sig, rst_n_sig, ante, cons, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define TCCE_ASSERT_NEXT(name, clk_sig, rst_n_sig, ante, cons, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console cell engine package
// Beat types, character codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

	localparam int CHAR_W     = 8;
	localparam int ATTR_W     = 8;
	localparam int CELL_W     = CHAR_W + ATTR_W;
	localparam int COORD_W    = 8;
	localparam int ROW_W      = 5;
	localparam int COL_W      = 7;
	localparam int LIN_W      = 11;
	localparam int TAB_SPACES = 4;
	localparam int TAB_CNT_W  = $clog2(TAB_SPACES);

	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0A;

	typedef enum logic [2:0] {
		ACT_PUT        = 3'd0,
		ACT_SET_CURSOR = 3'd1,
		ACT_CLEAR      = 3'd2,
		ACT_SET_ATTR   = 3'd3,
		ACT_READ       = 3'd4
	} tcce_action_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [CHAR_W-1:0]  char_code;
		logic [ATTR_W-1:0]  attribute;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} tcce_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]  cursor_row_out;
		logic [COL_W-1:0]  cursor_col_out;
		logic [LIN_W-1:0]  cursor_linear;
		logic [CELL_W-1:0] cell_data;
		logic              scrolled;
	} tcce_result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic step;
		logic step_space;
		logic set_cursor;
		logic set_attr;
		logic home;
		logic read_issue;
		logic read_capture;
		logic sweep_init;
		logic sweep_run;
		logic sweep_copy;
		logic load_out;
	} tcce_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [2:0] action;
		logic       is_tab;
		logic       step_scroll;
		logic       sweep_last;
		logic       out_busy;
	} tcce_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcce_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/tcce_ctrl.sv @@
// ----------------------------------------------------------------------------
// Text console controller
// Sequences each action: decode, character steps, store sweeps, result beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cell_engine_assert.svh"

module tcce_ctrl
	import tcce_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_stall,
	output tcce_cmd_t         cmd,
	input  wire tcce_status_t status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_STEP,
		ST_SWEEP,
		ST_RWAIT,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [TAB_CNT_W-1:0] tab_cnt_q;
	logic                 copy_q;
	logic                 init_q;

	assign item_stall = (state_q != ST_IDLE);

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = item_valid;
			end
			ST_EXEC: begin
				unique case (tcce_action_t'(status.action))
					ACT_SET_CURSOR: cmd.set_cursor = 1'b1;
					ACT_CLEAR: begin
						cmd.set_attr   = 1'b1;
						cmd.home       = 1'b1;
						cmd.sweep_init = 1'b1;
					end
					ACT_SET_ATTR: cmd.set_attr = 1'b1;
					ACT_READ: cmd.read_issue = 1'b1;
					default: ;
				endcase
			end
			ST_STEP: begin
				cmd.step       = 1'b1;
				cmd.step_space = status.is_tab;
				if (status.step_scroll) begin
					cmd.sweep_init = 1'b1;
					cmd.sweep_copy = 1'b1;
				end
			end
			ST_SWEEP: begin
				cmd.sweep_run  = 1'b1;
				cmd.sweep_copy = copy_q;
			end
			ST_RWAIT: begin
				cmd.read_capture = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out = !status.out_busy;
			end
			default: ;
		endcase
	end

	// Hold state; the store is filled with blanks right after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			tab_cnt_q <= '0;
			copy_q    <= 1'b0;
			init_q    <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (tcce_action_t'(status.action))
						ACT_PUT: begin
							tab_cnt_q <= status.is_tab ? TAB_CNT_W'(TAB_SPACES - 1) : '0;
							state_q   <= ST_STEP;
						end
						ACT_CLEAR: begin
							copy_q  <= 1'b0;
							state_q <= ST_SWEEP;
						end
						ACT_READ: state_q <= ST_RWAIT;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_STEP: begin
					if (status.step_scroll) begin
						copy_q  <= 1'b1;
						state_q <= ST_SWEEP;
					end else if (tab_cnt_q != '0) begin
						tab_cnt_q <= tab_cnt_q - 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SWEEP: begin
					if (status.sweep_last) begin
						if (init_q) begin
							init_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else if (copy_q && tab_cnt_q != '0) begin
							tab_cnt_q <= tab_cnt_q - 1'b1;
							state_q   <= ST_STEP;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RWAIT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TCCE_ASSERT_NEXT(a_accept_exec, clk, arst_n, cmd.accept, state_q == ST_EXEC, "accepted beat did not start execution")
	`TCCE_ASSERT_SAME(a_tab_in_put, clk, arst_n, tab_cnt_q != '0, state_q == ST_STEP || state_q == ST_SWEEP, "tab count live outside a character write")
	`TCCE_ASSERT_NEXT(a_sweep_exit, clk, arst_n, state_q == ST_SWEEP && status.sweep_last, state_q != ST_SWEEP, "sweep did not end at last cell")

endmodule

`default_nettype wire

@@ hw/rtl/tcce_dp.sv @@
// ----------------------------------------------------------------------------
// Text console datapath
// Cursor, attribute, cell store, sweep counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cell_engine_assert.svh"

module tcce_dp
	import tcce_pkg::*;
#(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire tcce_item_t item,
	output tcce_result_t    result,
	output logic            result_valid,
	input  wire logic       result_stall,
	input  wire tcce_cmd_t  cmd,
	output tcce_status_t    status
);

	localparam int CELLS = COLS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int LW    = (AW > LIN_W) ? AW : LIN_W;

	localparam logic [AW-1:0]    COLS_A      = AW'(COLS);
	localparam logic [AW-1:0]    LAST_A      = AW'(CELLS - 1);
	localparam logic [AW-1:0]    COPY_END    = AW'(CELLS - COLS);
	localparam logic [AW-1:0]    COPY_RD_END = AW'(CELLS - COLS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] LAST_COL    = COL_W'(COLS - 1);

	tcce_item_t        item_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ATTR_W-1:0] attr_q;
	logic [AW-1:0]     sw_q;
	logic [CELL_W-1:0] cell_q;
	logic              scrolled_q;
	tcce_result_t      result_q;
	logic              result_valid_q;

	logic [CHAR_W-1:0] step_ch;
	logic [COL_W:0]    col_ext;
	logic [COL_W:0]    ncol;
	logic              inc;
	logic              st_we;
	logic [COL_W-1:0]  st_col;
	logic [CHAR_W-1:0] st_char;
	logic              step_scroll;
	logic [ROW_W-1:0]  nrow;
	logic [AW-1:0]     step_addr;

	logic [ROW_W-1:0]  crow;
	logic [COL_W-1:0]  ccol;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     cur_addr;
	logic [LW-1:0]     lin_full;

	logic [AW:0]       sw_plus;
	logic              copy_rd_ok;
	logic              sweep_last;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Work out one character step from the cursor
	assign step_ch = cmd.step_space ? CH_BLANK : item_q.char_code;
	assign col_ext = {1'b0, col_q};

	always_comb begin
		ncol    = col_ext;
		inc     = 1'b0;
		st_we   = 1'b0;
		st_col  = col_q;
		st_char = step_ch;
		case (step_ch)
			CH_LF: begin
				ncol = '0;
				inc  = 1'b1;
			end
			CH_CR: begin
				ncol = '0;
			end
			CH_BS: begin
				if (col_q != '0) begin
					ncol    = col_ext - 1'b1;
					st_we   = 1'b1;
					st_col  = col_q - 1'b1;
					st_char = CH_BLANK;
				end
			end
			default: begin
				st_we = 1'b1;
				ncol  = col_ext + 1'b1;
			end
		endcase
		// Wrap at the line end
		if (ncol >= (COL_W + 1)'(COLS)) begin
			ncol = '0;
			inc  = 1'b1;
		end
	end

	assign step_scroll = inc && (row_q == LAST_ROW);
	assign nrow        = (inc && !step_scroll) ? row_q + 1'b1 : row_q;
	assign step_addr   = AW'(row_q) * COLS_A + AW'(st_col);

	// Clamp target coordinates to the screen
	assign crow = (item_q.row >= COORD_W'(ROWS)) ? LAST_ROW : item_q.row[ROW_W-1:0];
	assign ccol = (item_q.col >= COORD_W'(COLS)) ? LAST_COL : item_q.col[COL_W-1:0];
	assign rd_addr  = AW'(crow) * COLS_A + AW'(ccol);
	assign cur_addr = AW'(row_q) * COLS_A + AW'(col_q);
	assign lin_full = LW'(cur_addr);

	// Sweep: copy each cell up one row, then blank the tail; for clear, blank every cell
	assign sw_plus    = {1'b0, sw_q} + (AW + 1)'(COLS + 1);
	assign copy_rd_ok = (sw_q < COPY_RD_END);
	assign sweep_last = (sw_q == LAST_A);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = step_addr;
		ram_wdata = {attr_q, st_char};
		if (cmd.sweep_run) begin
			ram_we    = 1'b1;
			ram_waddr = sw_q;
			ram_wdata = (cmd.sweep_copy && sw_q < COPY_END) ? ram_rdata : {attr_q, CH_BLANK};
		end else if (cmd.step && st_we) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rd_addr;
		if (cmd.sweep_init && cmd.sweep_copy) begin
			ram_re    = 1'b1;
			ram_raddr = COLS_A;
		end else if (cmd.sweep_run && cmd.sweep_copy && copy_rd_ok) begin
			ram_re    = 1'b1;
			ram_raddr = sw_plus[AW-1:0];
		end else if (cmd.read_issue) begin
			ram_re = 1'b1;
		end
	end

	tcce_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Advance cursor, attribute, sweep counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q          <= '0;
			col_q          <= '0;
			attr_q         <= RESET_ATTR;
			sw_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				row_q <= nrow;
				col_q <= ncol[COL_W-1:0];
			end else if (cmd.set_cursor) begin
				row_q <= crow;
				col_q <= ccol;
			end else if (cmd.home) begin
				row_q <= '0;
				col_q <= '0;
			end
			if (cmd.set_attr) begin
				attr_q <= item_q.attribute;
			end
			if (cmd.sweep_init) begin
				sw_q <= '0;
			end else if (cmd.sweep_run) begin
				sw_q <= sweep_last ? '0 : sw_q + 1'b1;
			end
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Hold the item and build the result beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q     <= item;
			cell_q     <= '0;
			scrolled_q <= 1'b0;
		end else begin
			if (cmd.step && step_scroll) begin
				scrolled_q <= 1'b1;
			end
			if (cmd.read_capture) begin
				cell_q <= ram_rdata;
			end
		end
		if (cmd.load_out) begin
			result_q.cursor_row_out <= row_q;
			result_q.cursor_col_out <= col_q;
			result_q.cursor_linear  <= lin_full[LIN_W-1:0];
			result_q.cell_data      <= cell_q;
			result_q.scrolled       <= scrolled_q;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	assign status.action      = item_q.action;
	assign status.is_tab      = (item_q.char_code == CH_TAB);
	assign status.step_scroll = step_scroll;
	assign status.sweep_last  = sweep_last;
	assign status.out_busy    = result_valid_q && result_stall;

	`TCCE_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.load_out, !(result_valid_q && result_stall), "result beat overwritten while stalled")
	`TCCE_ASSERT_NEXT(a_scroll_row, clk, arst_n, cmd.step && step_scroll, row_q == LAST_ROW, "cursor left last row on scroll")

endmodule

`default_nettype wire

@@ hw/rtl/text_console_cell_engine.sv @@
// A tab is written as four blank cell steps. Each scroll sweeps all
// SCREEN_COLUMNS*SCREEN_ROWS cells (one cell copy per cycle through the store's single
// write port); clear sweeps every cell, blanking it in the new attribute.
// One item at a time: the next beat can be taken the cycle after the result is loaded.
// After reset the store is blanked, one cell a cycle, with item_stall high.
// ----------------------------------------------------------------------------
// Text console cell engine
// Character-cell console with cursor, current attribute and scrolling store.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_engine
	import tcce_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_stall,
	input  wire tcce_item_t   item,
	output logic              result_valid,
	input  wire logic         result_stall,
	output tcce_result_t      result
);

	tcce_cmd_t    cmd;
	tcce_status_t status;

	tcce_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.cmd        (cmd),
		.status     (status)
	);

	tcce_dp #(
		.COLS (SCREEN_COLUMNS),
		.ROWS (SCREEN_ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

`default_nettype wire

@@ tb/text_console_cell_engine_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console cell engine checker
// Watches the item and result channels, keeps its own copy of the screen,
// cursor and attribute, predicts one result per accepted item beat and
// compares every accepted result beat field by field in order.
// ----------------------------------------------------------------------------

module text_console_cell_engine_checker
	import tcce_pkg::*;
#(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	input  wire logic         item_stall,
	input  wire tcce_item_t   item,
	input  wire logic         result_valid,
	input  wire logic         result_stall,
	input  wire tcce_result_t result,
	output int                fail_count,
	output int                pending_results
);

	localparam int CELLS = COLS * ROWS;

	// Shadow console state
	logic [CELL_W-1:0] screen_cells [CELLS];
	int unsigned       cur_row;
	int unsigned       cur_col;
	logic [ATTR_W-1:0] cur_attr;

	// Predicted results, oldest first
	tcce_result_t      console_results[$];

	// Fill every cell with a blank in the given attribute
	function automatic void blank_screen(input logic [ATTR_W-1:0] attr);
		for (int i = 0; i < CELLS; i++)
			screen_cells[i] = {attr, CH_BLANK};
	endfunction

	// Clamp an 8-bit coordinate to the last valid index
	function automatic int unsigned clamp_coord(input logic [COORD_W-1:0] v, input int unsigned lim);
		return (v >= lim) ? lim - 1 : int'(v);
	endfunction

	// Apply one non-tab character; return 1 when the screen scrolled
	function automatic bit put_glyph(input logic [CHAR_W-1:0] ch);
		if (ch == CH_LF) begin
			cur_col = 0;
			cur_row++;
		end else if (ch == CH_CR) begin
			cur_col = 0;
		end else if (ch == CH_BS) begin
			if (cur_col > 0) begin
				cur_col--;
				screen_cells[cur_row * COLS + cur_col] = {cur_attr, CH_BLANK};
			end
		end else begin
			screen_cells[cur_row * COLS + cur_col] = {cur_attr, ch};
			cur_col++;
		end
		if (cur_col >= COLS) begin
			cur_col = 0;
			cur_row++;
		end
		// Shift rows up and blank the bottom row
		if (cur_row >= ROWS) begin
			for (int i = 0; i < CELLS - COLS; i++)
				screen_cells[i] = screen_cells[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++)
				screen_cells[i] = {cur_attr, CH_BLANK};
			cur_row = ROWS - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the shadow state by one item and form its result
	function automatic tcce_result_t predict_console_result(input tcce_item_t it);
		tcce_result_t      res;
		logic [CELL_W-1:0] read_data;
		bit                did_scroll;
		int unsigned       r;
		int unsigned       c;
		read_data  = '0;
		did_scroll = 1'b0;
		case (it.action)
			ACT_PUT: begin
				if (it.char_code == CH_TAB) begin
					for (int k = 0; k < TAB_SPACES; k++)
						if (put_glyph(CH_BLANK))
							did_scroll = 1'b1;
				end else begin
					did_scroll = put_glyph(it.char_code);
				end
			end
			ACT_SET_CURSOR: begin
				cur_row = clamp_coord(it.row, ROWS);
				cur_col = clamp_coord(it.col, COLS);
			end
			ACT_CLEAR: begin
				cur_attr = it.attribute;
				blank_screen(it.attribute);
				cur_row = 0;
				cur_col = 0;
			end
			ACT_SET_ATTR: begin
				cur_attr = it.attribute;
			end
			ACT_READ: begin
				r = clamp_coord(it.row, ROWS);
				c = clamp_coord(it.col, COLS);
				read_data = screen_cells[r * COLS + c];
			end
			default: ;
		endcase
		res.cursor_row_out = ROW_W'(cur_row);
		res.cursor_col_out = COL_W'(cur_col);
		res.cursor_linear  = LIN_W'(cur_row * COLS + cur_col);
		res.cell_data      = read_data;
		res.scrolled       = did_scroll;
		return res;
	endfunction

	// Print one mismatch line and count it
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count      = 0;
		pending_results = 0;
		blank_screen(RESET_ATTR);
		cur_row  = 0;
		cur_col  = 0;
		cur_attr = RESET_ATTR;
	end

	// Compare result beats, then predict for item beats
	always @(posedge clk) begin
		tcce_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (console_results.size() == 0) begin
					report_mismatch("result beat with nothing pending", 32'(result), 32'd0);
				end else begin
					want = console_results.pop_front();
					if (result.cursor_row_out !== want.cursor_row_out)
						report_mismatch("cursor_row_out", 32'(result.cursor_row_out),
							32'(want.cursor_row_out));
					if (result.cursor_col_out !== want.cursor_col_out)
						report_mismatch("cursor_col_out", 32'(result.cursor_col_out),
							32'(want.cursor_col_out));
					if (result.cursor_linear !== want.cursor_linear)
						report_mismatch("cursor_linear", 32'(result.cursor_linear),
							32'(want.cursor_linear));
					if (result.cell_data !== want.cell_data)
						report_mismatch("cell_data", 32'(result.cell_data),
							32'(want.cell_data));
					if (result.scrolled !== want.scrolled)
						report_mismatch("scrolled", 32'(result.scrolled), 32'(want.scrolled));
				end
			end
			if (item_valid && !item_stall)
				console_results.push_back(predict_console_result(item));
			pending_results <= console_results.size();
		end
	end

endmodule

@@ tb/tb_text_console_cell_engine.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console cell engine testbench
// Drives directed and weighted random console actions through the item
// channel under three idle mixes and one long result hold-off, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module tb_text_console_cell_engine
	import tcce_pkg::*;
();

	localparam int COLS             = 80;
	localparam int ROWS             = 25;
	localparam int RANDOM_PER_PHASE = 430;
	localparam int HOLD_CYCLES      = 400;
	localparam int DRAIN_CYCLES     = 50;

	logic         clk          = 1'b0;
	logic         arst_n       = 1'b0;
	logic         item_valid   = 1'b0;
	logic         item_stall;
	tcce_item_t   item         = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	tcce_result_t result;

	int fail_count;
	int pending_results;
	int send_idle_pct  = 9;
	int recv_idle_pct  = 45;
	bit hold_phase     = 1'b0;

	text_console_cell_engine #(
		.SCREEN_COLUMNS(COLS),
		.SCREEN_ROWS   (ROWS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	text_console_cell_engine_checker #(
		.COLS(COLS),
		.ROWS(ROWS)
	) checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.fail_count     (fail_count),
		.pending_results(pending_results)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Worst case is every item scrolling (a full store sweep each) plus stalls; allow
	// several times that.
	initial begin
		#150_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic tcce_item_t make_item(input logic [2:0] act, input logic [7:0] ch,
			input logic [7:0] attr, input logic [7:0] r, input logic [7:0] c);
		tcce_item_t it;
		it.action    = act;
		it.char_code = ch;
		it.attribute = attr;
		it.row       = r;
		it.col       = c;
		return it;
	endfunction

	// Weighted random action; fields an action ignores stay random
	function automatic tcce_item_t random_item();
		tcce_item_t  it;
		int unsigned pick;
		int unsigned sub;
		it   = make_item(3'($urandom_range(7)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		pick = $urandom_range(99);
		sub  = $urandom_range(99);
		if (pick < 55) begin
			it.action = ACT_PUT;
			if (sub < 68)
				it.char_code = 8'($urandom_range(8'h7E, 8'h20));
			else if (sub < 80)
				it.char_code = CH_LF;
			else if (sub < 84)
				it.char_code = CH_CR;
			else if (sub < 89)
				it.char_code = CH_TAB;
			else if (sub < 95)
				it.char_code = CH_BS;
		end else if (pick < 67) begin
			it.action = ACT_SET_CURSOR;
			// Favor the bottom rows so that scrolling happens often
			if (sub < 50) begin
				it.row = 8'($urandom_range(ROWS - 1, ROWS - 5));
				it.col = 8'($urandom_range(COLS - 1));
			end else if (sub < 75) begin
				it.row = 8'($urandom_range(ROWS - 1));
				it.col = 8'($urandom_range(COLS - 1));
			end
		end else if (pick < 69) begin
			it.action = ACT_CLEAR;
		end else if (pick < 75) begin
			it.action = ACT_SET_ATTR;
		end else if (pick < 95) begin
			it.action = ACT_READ;
			if (sub < 80) begin
				it.row = 8'($urandom_range(ROWS - 1));
				it.col = 8'($urandom_range(COLS - 1));
			end
		end else begin
			it.action = 3'($urandom_range(7, 5));
		end
		return it;
	endfunction

	// Offer one beat and hold it until accepted; valid stays high into the next beat
	task automatic send_beat(input tcce_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	// Receiver: random stalls, plus one long hold-off at the start of the last phase
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_phase && !hold_done) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Reset, stimulus, drain and verdict
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset contents, control characters, clamps, scroll paths
		send_beat(make_item(ACT_READ, 8'h00, 8'hFF, 8'd0, 8'd0));
		send_beat(make_item(ACT_PUT, 8'h41, 8'h00, 8'd255, 8'd255));
		send_beat(make_item(ACT_PUT, 8'h00, 8'h00, 8'd0, 8'd0));
		send_beat(make_item(ACT_PUT, 8'hFF, 8'hFF, 8'd255, 8'd255));
		send_beat(make_item(ACT_PUT, CH_TAB, 8'h00, 8'd0, 8'd0));
		send_beat(make_item(ACT_PUT, CH_BS, 8'h00, 8'd0, 8'd0));
		send_beat(make_item(ACT_PUT, CH_CR, 8'h00, 8'd0, 8'd0));
		send_beat(make_item(ACT_PUT, CH_BS, 8'h00, 8'd0, 8'd0));
		send_beat(make_item(ACT_SET_CURSOR, 8'h00, 8'h00, 8'd255, 8'd255));
		send_beat(make_item(ACT_READ, 8'h00, 8'h00, 8'd255, 8'd255));
		send_beat(make_item(ACT_PUT, 8'h5A, 8'h00, 8'd0, 8'd0));
		send_beat(make_item(ACT_SET_CURSOR, 8'h00, 8'h00, 8'(ROWS - 1), 8'(COLS - 2)));
		send_beat(make_item(ACT_PUT, CH_TAB, 8'h00, 8'd0, 8'd0));
		send_beat(make_item(ACT_SET_CURSOR, 8'h00, 8'h00, 8'(ROWS - 1), 8'd5));
		send_beat(make_item(ACT_PUT, CH_LF, 8'h00, 8'd0, 8'd0));
		send_beat(make_item(ACT_SET_ATTR, 8'h00, 8'hFF, 8'd0, 8'd0));
		send_beat(make_item(ACT_PUT, 8'h55, 8'h00, 8'd0, 8'd0));
		send_beat(make_item(ACT_READ, 8'h00, 8'h00, 8'(ROWS - 2), 8'd5));
		send_beat(make_item(ACT_READ, 8'h00, 8'h00, 8'(ROWS - 1), 8'd0));
		send_beat(make_item(ACT_SET_ATTR, 8'h00, 8'h00, 8'd0, 8'd0));
		send_beat(make_item(ACT_CLEAR, 8'h00, 8'hA5, 8'd0, 8'd0));
		send_beat(make_item(ACT_READ, 8'h00, 8'h00, 8'd12, 8'd40));
		send_beat(make_item(3'd5, 8'hFF, 8'hFF, 8'd255, 8'd255));
		send_beat(make_item(3'd6, 8'h00, 8'h00, 8'd0, 8'd0));
		send_beat(make_item(3'd7, 8'hFF, 8'hFF, 8'd255, 8'd255));

		// Random: sender idles lightly, receiver heavily
		repeat (RANDOM_PER_PHASE) send_beat(random_item());

		// Random: the other way round
		send_idle_pct = 45;
		recv_idle_pct <= 9;
		repeat (RANDOM_PER_PHASE) send_beat(random_item());

		// Random: back to back, with one long result hold-off
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		hold_phase    <= 1'b1;
		repeat (RANDOM_PER_PHASE) send_beat(random_item());
		item_valid <= 1'b0;

		// Drain outstanding results
		do
			@(posedge clk);
		while (pending_results != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
